/* design/tcw_pkg.sv */
// Shared constants and types of the tagged chunk walker.
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int POSITION_BITS = 24;
   localparam int COUNT_BITS = 16;
   localparam int BYTE_BITS = 8;
   localparam int TAG_BITS = 32;
   localparam int LENGTH_BITS = 32;
   localparam int INDEX_BITS = 16;
   localparam int OFFSET_BITS = 24;
   localparam int OCCURRENCE_BITS = 16;
   localparam int HDR_POS_BITS = 3;
   localparam int COMPARE_BITS = 32;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_COUNT_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WANTED_TAG = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WANTED_OCCURRENCE = 1'd1;

   localparam logic [HDR_POS_BITS-1:0] HDR_LAST_BYTE = 3'd7;

   localparam logic KIND_SECTION = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic                     kind;
      logic [INDEX_BITS-1:0]    section_index;
      logic [TAG_BITS-1:0]      section_tag;
      logic [OFFSET_BITS-1:0]   payload_offset;
      logic [LENGTH_BITS-1:0]   payload_length;
      logic                     tag_matches;
      logic                     is_wanted;
      logic                     file_valid;
      logic [INDEX_BITS-1:0]    section_total;
      logic [INDEX_BITS-1:0]    match_total;
      logic                     last_of_run;
   } rsp_type;

   typedef struct packed {
      logic    desc_valid;
      logic    summary_valid;
      rsp_type desc;
      rsp_type summary;
   } walk_out_type;

endpackage

/* design/tcw_req_if.sv */
// Request channel carrying one file byte per transfer.
`timescale 1ns / 1ps

interface tcw_req_if
   import tcw_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] data_byte;
   logic                 end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

/* design/tcw_rsp_if.sv */
// Result channel carrying section descriptors and end-of-file summaries.
`timescale 1ns / 1ps

interface tcw_rsp_if
   import tcw_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic                   kind;
   logic [INDEX_BITS-1:0]  section_index;
   logic [TAG_BITS-1:0]    section_tag;
   logic [OFFSET_BITS-1:0] payload_offset;
   logic [LENGTH_BITS-1:0] payload_length;
   logic                   tag_matches;
   logic                   is_wanted;
   logic                   file_valid;
   logic [INDEX_BITS-1:0]  section_total;
   logic [INDEX_BITS-1:0]  match_total;
   logic                   last_of_run;

   modport source (
      output valid, output kind, output section_index, output section_tag,
      output payload_offset, output payload_length, output tag_matches,
      output is_wanted, output file_valid, output section_total,
      output match_total, output last_of_run, input ready
   );
   modport sink (
      input valid, input kind, input section_index, input section_tag,
      input payload_offset, input payload_length, input tag_matches,
      input is_wanted, input file_valid, input section_total,
      input match_total, input last_of_run, output ready
   );
endinterface

/* design/tagged_chunk_walker_core.sv */
// Top level of the tagged chunk walker.
`timescale 1ns / 1ps

// The walker takes one file byte per request and can accept a new byte in every
// clock cycle while at least two of the four queue entries are free. A section
// descriptor comes out after the eighth header byte of each section, and an
// end-of-file summary after the byte marked as the last one; each result is queued
// behind any results still waiting. A steady stream runs at one byte per cycle as
// long as the response side drains one result per cycle. A byte that closes a
// header and ends the file gives two results, which enter the queue together and
// leave it in turn. The wanted tag and occurrence are to be written through the
// csr port between files; the walker does not enforce this.

module tagged_chunk_walker_core
   import tcw_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   tcw_req_if.sink                   req_chan,
   tcw_rsp_if.source                 rsp_chan,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   walk_out_type walk_out;
   rsp_type      rsp_data;
   logic         queue_ready;
   logic         req_fire;

   assign req_chan.ready = queue_ready;
   assign req_fire = req_chan.valid && queue_ready;

   tcw_walker u_walker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .in_fire          (req_fire),
      .in_byte          (req_chan.data_byte),
      .in_eof           (req_chan.end_of_file),
      .walk_out         (walk_out)
   );

   tcw_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .walk_in   (walk_out),
      .in_ready  (queue_ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   assign rsp_chan.kind = rsp_data.kind;
   assign rsp_chan.section_index = rsp_data.section_index;
   assign rsp_chan.section_tag = rsp_data.section_tag;
   assign rsp_chan.payload_offset = rsp_data.payload_offset;
   assign rsp_chan.payload_length = rsp_data.payload_length;
   assign rsp_chan.tag_matches = rsp_data.tag_matches;
   assign rsp_chan.is_wanted = rsp_data.is_wanted;
   assign rsp_chan.file_valid = rsp_data.file_valid;
   assign rsp_chan.section_total = rsp_data.section_total;
   assign rsp_chan.match_total = rsp_data.match_total;
   assign rsp_chan.last_of_run = rsp_data.last_of_run;

endmodule

/* design/tcw_walker.sv */
// Header parser, payload skipper and counters of the chunk walker.
`timescale 1ns / 1ps

module tcw_walker
   import tcw_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                      in_fire,
   input  logic [BYTE_BITS-1:0]      in_byte,
   input  logic                      in_eof,
   output walk_out_type              walk_out
);

   localparam logic [POSITION_BITS-1:0] POSITION_MAX = {POSITION_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic [TAG_BITS-1:0]        wanted_tag_ff;
   logic [OCCURRENCE_BITS-1:0] wanted_occurrence_ff;

   logic [HDR_POS_BITS-1:0]  header_position_ff, header_position_in;
   logic                     in_payload_ff, in_payload_in;
   logic [TAG_BITS-1:0]      tag_assembly_ff, tag_assembly_in;
   logic [LENGTH_BITS-1:0]   length_assembly_ff, length_assembly_in;
   logic [LENGTH_BITS-1:0]   payload_remaining_ff, payload_remaining_in;
   logic [POSITION_BITS-1:0] byte_position_ff, byte_position_in;
   logic                     position_overflow_ff, position_overflow_in;
   logic [COUNT_BITS-1:0]    sections_seen_ff, sections_seen_in;
   logic [COUNT_BITS-1:0]    matches_seen_ff, matches_seen_in;

   logic [LENGTH_BITS-1:0] lane_byte;
   logic [LENGTH_BITS-1:0] length_full;
   logic                   tag_match;
   logic                   header_done;
   logic                   summary_ok;

   assign lane_byte = LENGTH_BITS'(in_byte) << {header_position_ff[1:0], 3'b000};
   assign length_full = length_assembly_ff | lane_byte;
   assign tag_match = tag_assembly_ff == wanted_tag_ff;
   assign header_done = !in_payload_ff && header_position_ff == HDR_LAST_BYTE;

   always_comb begin
      header_position_in = header_position_ff;
      in_payload_in = in_payload_ff;
      tag_assembly_in = tag_assembly_ff;
      length_assembly_in = length_assembly_ff;
      payload_remaining_in = payload_remaining_ff;
      byte_position_in = byte_position_ff;
      position_overflow_in = position_overflow_ff;
      sections_seen_in = sections_seen_ff;
      matches_seen_in = matches_seen_ff;
      summary_ok = 1'b0;
      walk_out = '0;
      walk_out.desc.kind = KIND_SECTION;
      walk_out.summary.kind = KIND_SUMMARY;

      if (in_fire) begin
         if (byte_position_ff == POSITION_MAX) begin
            position_overflow_in = 1'b1;
         end else begin
            byte_position_in = POSITION_BITS'(byte_position_ff + 1'b1);
         end

         if (in_payload_ff) begin
            payload_remaining_in = LENGTH_BITS'(payload_remaining_ff - 1'b1);
            if (payload_remaining_in == '0) begin
               in_payload_in = 1'b0;
            end
         end else if (!header_position_ff[2]) begin
            tag_assembly_in = tag_assembly_ff | TAG_BITS'(lane_byte);
            header_position_in = HDR_POS_BITS'(header_position_ff + 1'b1);
         end else begin
            header_position_in = HDR_POS_BITS'(header_position_ff + 1'b1);
            length_assembly_in = length_full;
            if (header_done) begin
               walk_out.desc_valid = 1'b1;
               walk_out.desc.section_index = INDEX_BITS'(sections_seen_ff);
               walk_out.desc.section_tag = tag_assembly_ff;
               walk_out.desc.payload_offset = OFFSET_BITS'(byte_position_in);
               walk_out.desc.payload_length = length_full;
               walk_out.desc.tag_matches = tag_match;
               walk_out.desc.is_wanted = tag_match &&
                  (COMPARE_BITS'(matches_seen_ff) == COMPARE_BITS'(wanted_occurrence_ff));
               walk_out.desc.last_of_run = !in_eof;

               if (sections_seen_ff == COUNT_MAX) begin
                  position_overflow_in = 1'b1;
               end else begin
                  sections_seen_in = COUNT_BITS'(sections_seen_ff + 1'b1);
               end
               if (tag_match) begin
                  if (matches_seen_ff == COUNT_MAX) begin
                     position_overflow_in = 1'b1;
                  end else begin
                     matches_seen_in = COUNT_BITS'(matches_seen_ff + 1'b1);
                  end
               end
               if (length_full != '0) begin
                  in_payload_in = 1'b1;
                  payload_remaining_in = length_full;
               end
               tag_assembly_in = '0;
               length_assembly_in = '0;
            end
         end

         if (in_eof) begin
            summary_ok = header_position_in == '0 && !in_payload_in && !position_overflow_in;
            walk_out.summary_valid = 1'b1;
            walk_out.summary.file_valid = summary_ok;
            walk_out.summary.section_total = summary_ok ? INDEX_BITS'(sections_seen_in) : '0;
            walk_out.summary.match_total = summary_ok ? INDEX_BITS'(matches_seen_in) : '0;
            walk_out.summary.last_of_run = 1'b1;

            header_position_in = '0;
            in_payload_in = 1'b0;
            tag_assembly_in = '0;
            length_assembly_in = '0;
            payload_remaining_in = '0;
            byte_position_in = '0;
            position_overflow_in = 1'b0;
            sections_seen_in = '0;
            matches_seen_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_tag_ff <= '0;
         wanted_occurrence_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WANTED_TAG: begin
               wanted_tag_ff <= TAG_BITS'(csr_write_data);
            end
            CSR_WANTED_OCCURRENCE: begin
               wanted_occurrence_ff <= OCCURRENCE_BITS'(csr_write_data);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_position_ff <= '0;
         in_payload_ff <= 1'b0;
         tag_assembly_ff <= '0;
         length_assembly_ff <= '0;
         payload_remaining_ff <= '0;
         byte_position_ff <= '0;
         position_overflow_ff <= 1'b0;
         sections_seen_ff <= '0;
         matches_seen_ff <= '0;
      end else begin
         header_position_ff <= header_position_in;
         in_payload_ff <= in_payload_in;
         tag_assembly_ff <= tag_assembly_in;
         length_assembly_ff <= length_assembly_in;
         payload_remaining_ff <= payload_remaining_in;
         byte_position_ff <= byte_position_in;
         position_overflow_ff <= position_overflow_in;
         sections_seen_ff <= sections_seen_in;
         matches_seen_ff <= matches_seen_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> payload_remaining_ff != '0)
      else $error("Payload skip active with nothing left to skip.");

   assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> header_position_ff == '0)
      else $error("Payload skip active in the middle of a header.");

   assert property (@(posedge clock) disable iff (reset)
      (in_fire && in_eof) |=> (byte_position_ff == '0 && sections_seen_ff == '0 &&
                               !position_overflow_ff))
      else $error("Walk state not cleared after an end-of-file byte.");
`endif

endmodule

/* design/tcw_rsp_queue.sv */
// Four-entry result queue that decouples the walker from the result channel.
`timescale 1ns / 1ps

module tcw_rsp_queue
   import tcw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  walk_out_type walk_in,
   output logic         in_ready,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_type      out_data
);

   rsp_type                     entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;
   logic [QUEUE_COUNT_BITS-1:0] push_count;
   logic                        pop;
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_next;
   rsp_type                     first_push;

   assign push_count = QUEUE_COUNT_BITS'(walk_in.desc_valid) +
                       QUEUE_COUNT_BITS'(walk_in.summary_valid);
   assign first_push = walk_in.desc_valid ? walk_in.desc : walk_in.summary;
   assign wr_ptr_next = QUEUE_PTR_BITS'(wr_ptr_ff + 1'b1);
   assign pop = out_valid && out_ready;

   assign in_ready = count_ff <= QUEUE_COUNT_BITS'(QUEUE_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_data = entries_ff[rd_ptr_ff];

   assign wr_ptr_in = QUEUE_PTR_BITS'(wr_ptr_ff + push_count);
   assign rd_ptr_in = QUEUE_PTR_BITS'(rd_ptr_ff + pop);
   assign count_in = QUEUE_COUNT_BITS'(count_ff + push_count - QUEUE_COUNT_BITS'(pop));

   always_ff @(posedge clock) begin
      if (push_count != '0) begin
         entries_ff[wr_ptr_ff] <= first_push;
      end
      if (walk_in.desc_valid && walk_in.summary_valid) begin
         entries_ff[wr_ptr_next] <= walk_in.summary;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_COUNT_BITS'(QUEUE_DEPTH))
      else $error("Result queue holds more entries than it has.");

   assert property (@(posedge clock) disable iff (reset)
      (push_count == QUEUE_COUNT_BITS'(2) && !pop) |=>
         count_ff == QUEUE_COUNT_BITS'($past(count_ff) + 2'd2))
      else $error("Double push did not add two entries.");

   assert property (@(posedge clock) disable iff (reset)
      (push_count == '0 && pop) |=>
         count_ff == QUEUE_COUNT_BITS'($past(count_ff) - 1'b1))
      else $error("Lone pop did not remove one entry.");
`endif

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the tagged chunk walker core.
`timescale 1ns / 1ps

module tb_top;
   import tcw_pkg::*;

   typedef struct packed {
      logic [BYTE_BITS-1:0] data_byte;
      logic                 end_of_file;
   } file_byte_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_write_data;

   tcw_req_if req_if ();
   tcw_rsp_if rsp_if ();

   tagged_chunk_walker_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   file_byte_type file_stream[$];
   rsp_type predicted_records[$];

   logic [TAG_BITS-1:0] want_tag;
   logic [OCCURRENCE_BITS-1:0] want_occ;

   logic [HDR_POS_BITS-1:0] walk_hdr;
   logic walk_in_payload;
   logic [TAG_BITS-1:0] walk_tag;
   logic [LENGTH_BITS-1:0] walk_len;
   logic [LENGTH_BITS-1:0] walk_remaining;
   logic [POSITION_BITS-1:0] walk_pos;
   logic walk_overflow;
   logic [COUNT_BITS-1:0] walk_sections;
   logic [COUNT_BITS-1:0] walk_matches;

   logic [TAG_BITS-1:0] tag_pool[4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5445_5854, 32'h4154_4144};

   logic req_taken;
   int gap_left;
   int burst_left;
   int ready_left;
   int stall_left;
   file_byte_type next_byte;

   int bytes_queued = 0;
   int bytes_accepted = 0;
   int files_sent = 0;
   int settings_used = 0;
   int failures = 0;
   int descriptors_seen = 0;
   int summaries_seen = 0;
   int valid_files = 0;
   int wanted_hits = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic clear_walk();
      walk_hdr = '0;
      walk_in_payload = 1'b0;
      walk_tag = '0;
      walk_len = '0;
      walk_remaining = '0;
      walk_pos = '0;
      walk_overflow = 1'b0;
      walk_sections = '0;
      walk_matches = '0;
   endtask

   task automatic walk_byte(input logic [BYTE_BITS-1:0] b, input logic eof);
      rsp_type r;
      logic tag_hit;
      logic file_ok;
      if (walk_pos == '1) walk_overflow = 1'b1;
      else walk_pos = walk_pos + 1'b1;
      if (walk_in_payload) begin
         walk_remaining = walk_remaining - 1'b1;
         if (walk_remaining == 0) walk_in_payload = 1'b0;
      end else if (walk_hdr < 4) begin
         walk_tag = walk_tag | (32'(b) << (8 * walk_hdr));
         walk_hdr = walk_hdr + 1'b1;
      end else begin
         walk_len = walk_len | (32'(b) << (8 * (walk_hdr - 4)));
         walk_hdr = walk_hdr + 1'b1;
         if (walk_hdr == 0) begin
            tag_hit = (walk_tag == want_tag);
            r = '0;
            r.kind = KIND_SECTION;
            r.section_index = walk_sections;
            r.section_tag = walk_tag;
            r.payload_offset = walk_pos;
            r.payload_length = walk_len;
            r.tag_matches = tag_hit;
            r.is_wanted = tag_hit && (walk_matches == want_occ);
            r.last_of_run = !eof;
            predicted_records.push_back(r);
            if (walk_sections == '1) walk_overflow = 1'b1;
            else walk_sections = walk_sections + 1'b1;
            if (tag_hit) begin
               if (walk_matches == '1) walk_overflow = 1'b1;
               else walk_matches = walk_matches + 1'b1;
            end
            if (walk_len != 0) begin
               walk_in_payload = 1'b1;
               walk_remaining = walk_len;
            end
            walk_tag = '0;
            walk_len = '0;
         end
      end
      if (eof) begin
         file_ok = (walk_hdr == 0) && !walk_in_payload && !walk_overflow;
         r = '0;
         r.kind = KIND_SUMMARY;
         r.file_valid = file_ok;
         r.section_total = file_ok ? walk_sections : '0;
         r.match_total = file_ok ? walk_matches : '0;
         r.last_of_run = 1'b1;
         predicted_records.push_back(r);
         clear_walk();
      end
   endtask

   function automatic string show_rsp(input rsp_type r);
      return $sformatf({"kind=%0d idx=%0d tag=%h off=%0d len=%h match=%b wanted=%b",
                        " valid=%b sections=%0d matches=%0d last=%b"},
                       r.kind, r.section_index, r.section_tag, r.payload_offset,
                       r.payload_length, r.tag_matches, r.is_wanted, r.file_valid,
                       r.section_total, r.match_total, r.last_of_run);
   endfunction

   function automatic string field_diffs(input rsp_type e, input rsp_type a);
      string s;
      s = "";
      if (e.kind !== a.kind) s = {s, " kind"};
      if (e.section_index !== a.section_index) s = {s, " section_index"};
      if (e.section_tag !== a.section_tag) s = {s, " section_tag"};
      if (e.payload_offset !== a.payload_offset) s = {s, " payload_offset"};
      if (e.payload_length !== a.payload_length) s = {s, " payload_length"};
      if (e.tag_matches !== a.tag_matches) s = {s, " tag_matches"};
      if (e.is_wanted !== a.is_wanted) s = {s, " is_wanted"};
      if (e.file_valid !== a.file_valid) s = {s, " file_valid"};
      if (e.section_total !== a.section_total) s = {s, " section_total"};
      if (e.match_total !== a.match_total) s = {s, " match_total"};
      if (e.last_of_run !== a.last_of_run) s = {s, " last_of_run"};
      return s;
   endfunction

   task automatic note_failure(input string what);
      failures++;
      if (failures <= 10) $display("[%0t] %s", $time, what);
   endtask

   // The request side: one byte per request, sent in bursts with idle gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left <= 0;
         burst_left <= 0;
      end else if (!req_if.valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_if.valid <= 1'b0;
         end else if (file_stream.size() != 0) begin
            next_byte = file_stream.pop_front();
            req_if.data_byte <= next_byte.data_byte;
            req_if.end_of_file <= next_byte.end_of_file;
            req_if.valid <= 1'b1;
            if (burst_left > 1) begin
               burst_left <= burst_left - 1;
               gap_left <= 0;
            end else begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         ready_left <= 0;
         stall_left <= 0;
      end else if (ready_left != 0) begin
         ready_left <= ready_left - 1;
         rsp_if.ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         ready_left <= $urandom_range(1, 16);
         stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      string diffs;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            bytes_accepted++;
            walk_byte(req_if.data_byte, req_if.end_of_file);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.kind = rsp_if.kind;
            got.section_index = rsp_if.section_index;
            got.section_tag = rsp_if.section_tag;
            got.payload_offset = rsp_if.payload_offset;
            got.payload_length = rsp_if.payload_length;
            got.tag_matches = rsp_if.tag_matches;
            got.is_wanted = rsp_if.is_wanted;
            got.file_valid = rsp_if.file_valid;
            got.section_total = rsp_if.section_total;
            got.match_total = rsp_if.match_total;
            got.last_of_run = rsp_if.last_of_run;
            if (got.kind === KIND_SUMMARY) begin
               summaries_seen++;
               if (got.file_valid === 1'b1) valid_files++;
            end else begin
               descriptors_seen++;
               if (got.is_wanted === 1'b1) wanted_hits++;
            end
            if (predicted_records.size() == 0) begin
               note_failure($sformatf("Unexpected result: %s", show_rsp(got)));
            end else begin
               want = predicted_records.pop_front();
               diffs = field_diffs(want, got);
               if (diffs != "")
                  note_failure($sformatf("Mismatch in%s\n   expected %s\n   actual   %s",
                                         diffs, show_rsp(want), show_rsp(got)));
            end
         end
      end
   end

   task automatic queue_byte(input logic [BYTE_BITS-1:0] b, input logic eof);
      file_byte_type fb;
      while (bytes_queued - bytes_accepted >= 256) @(posedge clock);
      fb.data_byte = b;
      fb.end_of_file = eof;
      file_stream.push_back(fb);
      bytes_queued++;
   endtask

   task automatic queue_header(input logic [TAG_BITS-1:0] tag,
                               input logic [LENGTH_BITS-1:0] len, input logic ends_file);
      for (int i = 0; i < 8; i++)
         queue_byte(i < 4 ? tag[8*i +: 8] : len[8*(i-4) +: 8], ends_file && i == 7);
   endtask

   // Mostly well-formed files with random content; some are cut short, a few are noise.
   task automatic queue_random_file();
      logic [BYTE_BITS-1:0] chunk[$];
      logic [TAG_BITS-1:0] tag;
      logic [LENGTH_BITS-1:0] len;
      int style;
      int sections;
      logic huge;
      style = $urandom_range(0, 9);
      huge = 1'b0;
      if (style == 9) begin
         repeat ($urandom_range(1, 24)) chunk.push_back(8'($urandom));
      end else begin
         sections = $urandom_range(1, 4);
         for (int s = 0; s < sections && !huge; s++) begin
            case ($urandom_range(0, 3))
               0, 1: tag = want_tag;
               2: tag = tag_pool[$urandom_range(0, 3)];
               default: tag = $urandom;
            endcase
            if (style >= 7 && $urandom_range(0, 2) == 0) len = $urandom;
            else if ($urandom_range(0, 4) == 0) len = $urandom_range(7, 24);
            else len = $urandom_range(0, 6);
            for (int i = 0; i < 4; i++) chunk.push_back(tag[8*i +: 8]);
            for (int i = 0; i < 4; i++) chunk.push_back(len[8*i +: 8]);
            if (len > 64) huge = 1'b1;
            else repeat (len) chunk.push_back(8'($urandom));
         end
         if (style >= 7) chunk = chunk[0:$urandom_range(0, chunk.size() - 1)];
      end
      foreach (chunk[i]) queue_byte(chunk[i], i == chunk.size() - 1);
      files_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      if (idx == CSR_WANTED_TAG) want_tag = value;
      else want_occ = value[OCCURRENCE_BITS-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_filter(input logic [TAG_BITS-1:0] tag,
                             input logic [OCCURRENCE_BITS-1:0] occ);
      write_reg(CSR_WANTED_TAG, tag);
      write_reg(CSR_WANTED_OCCURRENCE, {16'($urandom), occ});
      settings_used++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (bytes_accepted != bytes_queued || predicted_records.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic run_random_phase(input logic [TAG_BITS-1:0] tag,
                                   input logic [OCCURRENCE_BITS-1:0] occ);
      int start;
      set_filter(tag, occ);
      start = bytes_queued;
      while (bytes_queued - start < 215) queue_random_file();
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_WANTED_TAG;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.end_of_file = 1'b0;
      rsp_if.ready = 1'b0;
      want_tag = '0;
      want_occ = '0;
      clear_walk();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed files: a header closing the file, a truncated maximal payload,
      // a file ending inside its header, and a short valid file with payload.
      set_filter(32'h4B4E_5548, 16'd0);
      queue_header(want_tag, 32'd0, 1'b1);
      queue_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b1);
      queue_header(32'h0000_0000, 32'd1, 1'b0);
      queue_byte(8'hFF, 1'b1);
      files_sent += 4;
      wait_idle();

      run_random_phase(32'h0000_0000, 16'd0);
      run_random_phase(32'hFFFF_FFFF, 16'd1);
      run_random_phase($urandom, 16'($urandom_range(0, 3)));
      run_random_phase(tag_pool[2], 16'd2);

      if (predicted_records.size() != 0) note_failure("Results still outstanding at the end");
      $display("Walked %0d files (%0d bytes) under %0d filter settings.",
               files_sent, bytes_queued, settings_used);
      $display("Checked %0d descriptors and %0d summaries (%0d valid), %0d wanted hits.",
               descriptors_seen, summaries_seen, valid_files, wanted_hits);
      if (failures == 0) begin
         $display("** tagged_chunk_walker_core: PASSED **");
      end else begin
         $display("%0d failures in total.", failures);
         $display("** tagged_chunk_walker_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Timed out with %0d results outstanding.", predicted_records.size());
      $display("** tagged_chunk_walker_core: FAILED **");
      $finish;
   end

endmodule

/* sim.f */
design/tcw_pkg.sv
design/tcw_req_if.sv
design/tcw_rsp_if.sv
design/tcw_walker.sv
design/tcw_rsp_queue.sv
design/tagged_chunk_walker_core.sv
dv/tb_top.sv
